// File: design/dda_pkg.sv
// shared types and constants for the dda line rasterizer
// used by dda_ctrl, dda_datapath and dda_line_rasterizer_top; no dependencies
`default_nettype none

package dda_pkg;

  localparam int unsigned COORD_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // action codes carried on in_tuser
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef enum logic {
    ST_READY,
    ST_DIV
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic start;     // start transaction accepted
    logic step;      // step transaction accepted
    logic div_run;   // run one divider iteration
    logic div_last;  // this iteration produces the final quotient bit
  } dda_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic reject;    // endpoints on the input lie behind the start
    logic out_busy;  // output register full and not drained this cycle
  } dda_status_t;

endpackage

`default_nettype wire

// File: design/dda_ctrl.sv
// controller for the dda line rasterizer: input handshake and divider sequencing
// depends on dda_pkg
`default_nettype none

module dda_ctrl #(
  parameter int unsigned FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_action,
  output logic                       in_tready,
  input  dda_pkg::dda_status_t       status,
  output dda_pkg::dda_cmd_t          cmd
);

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

  dda_pkg::ctl_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dda_pkg::ST_READY;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_tready    = 1'b0;
    fire         = 1'b0;
    cmd          = '0;
    case (state_r)
      dda_pkg::ST_READY: begin
        in_tready = !status.out_busy;
        fire      = in_tvalid && in_tready;
        cmd.start = fire && (in_action == dda_pkg::ACT_START);
        cmd.step  = fire && (in_action == dda_pkg::ACT_STEP);
        if (cmd.start && !status.reject) begin
          state_nxt = dda_pkg::ST_DIV;
          cnt_nxt   = '0;
        end
      end
      dda_pkg::ST_DIV: begin
        cmd.div_run  = 1'b1;
        cmd.div_last = (cnt_r == CNT_LAST);
        if (cmd.div_last) begin
          state_nxt = dda_pkg::ST_READY;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = dda_pkg::ST_READY;
        cnt_nxt   = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dda_pkg::ST_DIV) |-> !in_tready)
    else $error("input accepted while divider running");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("divider count out of range");

  a_div_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && !status.reject) |=> (state_r == dda_pkg::ST_DIV) && (cnt_r == '0))
    else $error("accepted start did not launch divider");
`endif

endmodule

`default_nettype wire

// File: design/dda_datapath.sv
// datapath for the dda line rasterizer: line state, serial divider, output register
// depends on dda_pkg
`default_nettype none

module dda_datapath #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  input  dda_pkg::dda_cmd_t          cmd,
  output dda_pkg::dda_status_t       status,
  input  wire logic                  out_tready,
  output logic                       out_valid,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic                       pixel_last,
  output logic                       pixel_idle,
  output logic                       pixel_rejected
);

  localparam int unsigned ACC_W  = COORD_BITS + FRAC_BITS;
  localparam int unsigned STEP_W = FRAC_BITS + 1;
  localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);

  // line state
  logic                  active_r;
  logic                  major_is_y_r;
  logic [COORD_BITS-1:0] major_pos_r;
  logic [COORD_BITS-1:0] major_end_r;
  logic [ACC_W-1:0]      minor_acc_r;
  logic [STEP_W-1:0]     minor_step_r;

  // divider
  logic [COORD_BITS:0]   rem_r;
  logic [COORD_BITS-1:0] den_r;
  logic [STEP_W-1:0]     quo_r;

  // output register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic                  last_r, idle_r, rej_r;

  // start decode
  logic [COORD_BITS-1:0] dx, dy, major_len, minor_len, minor_start;
  logic                  go_y;

  // step path
  logic [COORD_BITS-1:0] pos_inc;
  logic [ACC_W-1:0]      acc_inc, acc_round;
  logic [COORD_BITS-1:0] minor_rnd;
  logic [COORD_BITS-1:0] step_px, step_py;

  // divider iteration
  logic                  div_ge;
  logic [COORD_BITS:0]   rem_sub;
  logic [STEP_W-1:0]     quo_nxt;

  always_comb begin
    status.reject   = (end_x < start_x) || (end_y < start_y);
    status.out_busy = out_valid_r && !out_tready;

    dx   = end_x - start_x;
    dy   = end_y - start_y;
    go_y = dy > dx;
    if (go_y) begin
      major_len   = dy;
      minor_len   = dx;
      minor_start = start_x;
    end else begin
      major_len   = dx;
      minor_len   = dy;
      minor_start = start_y;
    end

    pos_inc   = major_pos_r + 1'b1;
    acc_inc   = minor_acc_r + ACC_W'(minor_step_r);
    acc_round = acc_inc + HALF_LSB;
    minor_rnd = acc_round[ACC_W-1:FRAC_BITS];
    if (major_is_y_r) begin
      step_px = minor_rnd;
      step_py = pos_inc;
    end else begin
      step_px = pos_inc;
      step_py = minor_rnd;
    end

    div_ge  = rem_r >= {1'b0, den_r};
    rem_sub = div_ge ? (rem_r - {1'b0, den_r}) : rem_r;
    quo_nxt = {quo_r[STEP_W-2:0], div_ge};
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        active_r <= !status.reject && (major_len != '0);
      end else if (cmd.step && active_r && (pos_inc == major_end_r)) begin
        active_r <= 1'b0;
      end
      if (cmd.start || cmd.step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // line state, divider and result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_is_y_r <= 1'b0;
      major_pos_r  <= '0;
      major_end_r  <= '0;
      minor_acc_r  <= '0;
      minor_step_r <= '0;
    end else begin
      if (cmd.start && !status.reject) begin
        major_is_y_r <= go_y;
        major_pos_r  <= go_y ? start_y : start_x;
        major_end_r  <= go_y ? end_y : end_x;
        minor_acc_r  <= {minor_start, FRAC_BITS'(0)};
      end else if (cmd.step && active_r) begin
        major_pos_r <= pos_inc;
        minor_acc_r <= acc_inc;
      end
      if (cmd.div_last) begin
        minor_step_r <= (den_r == '0) ? '0 : quo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= {1'b0, minor_len};
      den_r <= major_len;
      quo_r <= '0;
    end else if (cmd.div_run) begin
      rem_r <= {rem_sub[COORD_BITS-1:0], 1'b0};
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idle_r <= 1'b0;
      if (status.reject) begin
        px_r   <= '0;
        py_r   <= '0;
        last_r <= 1'b0;
        rej_r  <= 1'b1;
      end else begin
        px_r   <= start_x;
        py_r   <= start_y;
        last_r <= (major_len == '0);
        rej_r  <= 1'b0;
      end
    end else if (cmd.step) begin
      rej_r <= 1'b0;
      if (active_r) begin
        px_r   <= step_px;
        py_r   <= step_py;
        last_r <= (pos_inc == major_end_r);
        idle_r <= 1'b0;
      end else begin
        px_r   <= '0;
        py_r   <= '0;
        last_r <= 1'b0;
        idle_r <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign pixel_x        = px_r;
  assign pixel_y        = py_r;
  assign pixel_last     = last_r;
  assign pixel_idle     = idle_r;
  assign pixel_rejected = rej_r;

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(idle_r && rej_r) && !(last_r && (idle_r || rej_r)))
    else $error("conflicting result flags");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (idle_r || rej_r)) |-> (px_r == '0) && (py_r == '0))
    else $error("idle or rejected result carries a pixel");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && active_r && (pos_inc == major_end_r)) |=> !active_r && last_r)
    else $error("line still active after its last pixel");
`endif

endmodule

`default_nettype wire

// File: design/dda_line_rasterizer_top.sv
// A step transaction (tuser = 1) is taken every cycle while the result side keeps
// up: the next pixel comes from one add on the major coordinate and one on the Q16
// minor accumulator, and lands in the output register. A start transaction
// (tuser = 0) returns its start pixel through the output register, then the
// increment minor/major is formed by a restoring divider that retires one quotient
// bit per cycle, and no further transaction is accepted until the divider has
// finished. A rejected start does not run the divider. Lines must run
// toward larger x and larger y; anything else comes back with the rejected flag.
//
// top level of the dda line rasterizer; depends on dda_pkg, dda_ctrl, dda_datapath
`default_nettype none

module dda_line_rasterizer_top #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // start_x, start_y, end_x, end_y
  input  wire logic             in_tuser,   // action
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // pixel_x, pixel_y
  output logic                  out_tlast,  // last
  output logic [1:0]            out_tuser   // idle, rejected
);

  localparam int unsigned C = COORD_BITS;

  dda_pkg::dda_cmd_t    cmd;
  dda_pkg::dda_status_t status;
  logic [C-1:0]         pixel_x, pixel_y;
  logic                 pixel_idle, pixel_rejected;

  dda_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dda_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .start_x        (in_tdata[C-1:0]),
    .start_y        (in_tdata[2*C-1:C]),
    .end_x          (in_tdata[3*C-1:2*C]),
    .end_y          (in_tdata[4*C-1:3*C]),
    .cmd            (cmd),
    .status         (status),
    .out_tready     (out_tready),
    .out_valid      (out_tvalid),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .pixel_last     (out_tlast),
    .pixel_idle     (pixel_idle),
    .pixel_rejected (pixel_rejected)
  );

  assign out_tdata = OUT_W'({pixel_y, pixel_x});
  assign out_tuser = {pixel_rejected, pixel_idle};

endmodule

`default_nettype wire

// File: tb/dda_line_rasterizer_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for dda_line_rasterizer_top: stream driver and monitor
// against a cycle-free line predictor; depends on dda_pkg and the rtl under design/

module dda_line_rasterizer_top_tb;

  localparam int unsigned CB    = dda_pkg::COORD_BITS_DEF;
  localparam int unsigned FB    = dda_pkg::FRAC_BITS_DEF;
  localparam int unsigned IN_W  = ((4 * CB + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((2 * CB + 7) / 8) * 8;
  localparam int unsigned CMAX  = (1 << CB) - 1;
  localparam int unsigned LIMIT = 300000;
  localparam logic [CB+FB:0] HALF = (CB+FB+1)'(1) << (FB - 1);

  typedef struct packed {
    logic          action;
    logic [CB-1:0] sx, sy, ex, ey;
    logic          sync;   // sender waits for all pixels before offering this one
    logic          hold;   // receiver starts a long hold-off when this is offered
    logic          gappy;  // sender may idle before this one
    logic          tail;   // no idling from here on
  } line_cmd_t;

  typedef struct packed {
    logic [CB-1:0] px, py;
    logic          last, idle, rejected;
  } pixel_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;
  logic [1:0]       out_tuser;

  line_cmd_t line_cmds[$];
  pixel_t    pending_pixels[$];
  line_cmd_t cur_cmd;
  int        n_cmds = 0;
  int        accepted_cnt = 0;
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  int        tx_gap = 0;
  int        rx_stall = 0;
  int        rx_hold = 0;
  bit        rx_busy_mode = 1'b1;
  bit        long_hold_req = 1'b0;
  bit        tail_phase = 1'b0;

  // predictor state
  logic             ln_active = 1'b0;
  logic             ln_major_y = 1'b0;
  logic [CB-1:0]    ln_pos = '0;
  logic [CB-1:0]    ln_end = '0;
  logic [CB+FB-1:0] ln_acc = '0;
  logic [FB:0]      ln_inc = '0;

  dda_line_rasterizer_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pixel_t plotted(logic last);
    pixel_t         p;
    logic [CB+FB:0] rnd;
    rnd = {1'b0, ln_acc} + HALF;  // round to nearest, halves up
    p = '0;
    p.last = last;
    if (ln_major_y) begin
      p.px = rnd[CB+FB-1:FB];
      p.py = ln_pos;
    end else begin
      p.px = ln_pos;
      p.py = rnd[CB+FB-1:FB];
    end
    return p;
  endfunction

  function automatic pixel_t rasterize(line_cmd_t c);
    pixel_t           p;
    logic [CB-1:0]    dx, dy, maj_len, min_len, min_start;
    logic [CB+FB-1:0] quo;
    p = '0;
    if (c.action == dda_pkg::ACT_START) begin
      if (c.ex < c.sx || c.ey < c.sy) begin
        ln_active = 1'b0;
        p.rejected = 1'b1;
        return p;
      end
      dx = c.ex - c.sx;
      dy = c.ey - c.sy;
      ln_major_y = dy > dx;
      if (ln_major_y) begin
        ln_pos = c.sy; ln_end = c.ey; maj_len = dy; min_len = dx; min_start = c.sx;
      end else begin
        ln_pos = c.sx; ln_end = c.ex; maj_len = dx; min_len = dy; min_start = c.sy;
      end
      ln_acc = {min_start, {FB{1'b0}}};
      if (maj_len != 0) begin
        quo = {min_len, {FB{1'b0}}} / {{FB{1'b0}}, maj_len};
        ln_inc = quo[FB:0];
      end else begin
        ln_inc = '0;
      end
      ln_active = maj_len != 0;
      return plotted(maj_len == 0);
    end
    if (!ln_active) begin
      p.idle = 1'b1;
      return p;
    end
    ln_pos = ln_pos + 1'b1;
    ln_acc = ln_acc + ln_inc;
    if (ln_pos == ln_end) begin
      ln_active = 1'b0;
      return plotted(1'b1);
    end
    return plotted(1'b0);
  endfunction

  task automatic add_cmd(logic action, int sx, int sy, int ex, int ey);
    line_cmd_t c;
    c = '0;
    c.action = action;
    c.sx = CB'(sx); c.sy = CB'(sy); c.ex = CB'(ex); c.ey = CB'(ey);
    c.tail = n_cmds >= 570;
    c.gappy = !c.tail;
    line_cmds.push_back(c);
    n_cmds++;
  endtask

  task automatic add_steps(int n);
    for (int i = 0; i < n; i++)
      add_cmd(dda_pkg::ACT_STEP, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
              $urandom_range(0, CMAX), $urandom_range(0, CMAX));
  endtask

  // well-formed line: start plus its steps, sometimes cut short or overrun
  task automatic add_line(int max_len);
    int maj, mnr, dx, dy, sx, sy, n;
    maj = ($urandom_range(0, 9) == 0) ? $urandom_range(0, max_len) : $urandom_range(0, 20);
    mnr = $urandom_range(0, maj);
    if ($urandom_range(0, 1)) begin
      dx = maj; dy = mnr;
    end else begin
      dx = mnr; dy = maj;
    end
    sx = $urandom_range(0, CMAX - dx);
    sy = $urandom_range(0, CMAX - dy);
    add_cmd(dda_pkg::ACT_START, sx, sy, sx + dx, sy + dy);
    case ($urandom_range(0, 7))
      0: n = $urandom_range(0, maj);
      1: n = maj + $urandom_range(1, 3);
      default: n = maj;
    endcase
    add_steps(n);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  initial begin
    bit hold_done, sync_done;
    hold_done = 1'b0;
    sync_done = 1'b0;
    // directed part
    add_steps(1);                                        // step with no line
    add_cmd(dda_pkg::ACT_START, 0, 0, 0, 0);             // single point at origin
    add_cmd(dda_pkg::ACT_START, CMAX, CMAX, CMAX, CMAX); // single point at far corner
    add_cmd(dda_pkg::ACT_START, CMAX - 3, 5, CMAX, 5);   // horizontal to the edge
    add_steps(4);                                        // last one finds no line
    add_cmd(dda_pkg::ACT_START, 7, CMAX - 3, 7, CMAX);   // vertical to the edge
    add_steps(3);
    add_cmd(dda_pkg::ACT_START, 0, 0, 2, 1);             // half increment rounds up
    add_steps(2);
    add_cmd(dda_pkg::ACT_START, 0, 0, CMAX, CMAX);       // full diagonal, abandoned
    add_steps(2);
    add_cmd(dda_pkg::ACT_START, 10, 0, 5, 0);            // backward in x drops the line
    add_steps(1);
    add_cmd(dda_pkg::ACT_START, 0, 10, 0, 5);            // backward in y
    add_cmd(dda_pkg::ACT_START, 3, 3, 6, 6);             // dx equal dy picks major x
    add_steps(1);
    add_cmd(dda_pkg::ACT_START, 100, 200, 103, 201);     // new start while active
    add_steps(3);
    // random part
    while (n_cmds < 650) begin
      if (!hold_done && n_cmds >= 200) begin
        hold_done = 1'b1;
        add_cmd(dda_pkg::ACT_START, 0, 9, 60, 9);
        line_cmds[$].hold = 1'b1;
        for (int i = 0; i < 60; i++) begin
          add_steps(1);
          line_cmds[$].gappy = 1'b0;
        end
      end else if (!sync_done && n_cmds >= 400) begin
        sync_done = 1'b1;
        add_line(120);
        add_cmd(dda_pkg::ACT_START, 1, 2, 5, 4);
        line_cmds[$].sync = 1'b1;
        add_steps(4);
      end else begin
        case ($urandom_range(0, 9))
          0: add_cmd(dda_pkg::ACT_START, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
                     $urandom_range(0, CMAX), $urandom_range(0, CMAX));
          1: add_steps($urandom_range(1, 3));
          default: add_line(120);
        endcase
      end
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_cnt < n_cmds || pending_pixels.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
    if (err_cnt == 0)
      $display("dda_line_rasterizer_top_tb: clean");
    else
      $display("dda_line_rasterizer_top_tb: errors");
    $finish;
  end

  // driver
  always @(posedge clk) begin : drive_proc
    logic next_valid;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_pixels.push_back(rasterize(cur_cmd));
        accepted_cnt++;
      end
      if (!(in_tvalid && !in_tready)) begin
        next_valid = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (line_cmds.size() > 0) begin
          if (line_cmds[0].sync && pending_pixels.size() > 0) begin
            // pause until the block has drained
          end else if (line_cmds[0].gappy && $urandom_range(0, 5) == 0) begin
            tx_gap = $urandom_range(0, 16);
          end else begin
            cur_cmd = line_cmds.pop_front();
            next_valid = 1'b1;
            in_tdata <= IN_W'({cur_cmd.ey, cur_cmd.ex, cur_cmd.sy, cur_cmd.sx});
            in_tuser <= cur_cmd.action;
            if (cur_cmd.hold) long_hold_req = 1'b1;
            if (cur_cmd.tail) tail_phase = 1'b1;
          end
        end
        in_tvalid <= next_valid;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold = 79;
        out_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else if (!tail_phase && rx_busy_mode && $urandom_range(0, 4) == 0) begin
        rx_stall = $urandom_range(0, 16);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if ($urandom_range(0, 149) == 0) rx_busy_mode = !rx_busy_mode;
    end
  end

  // monitor
  always @(posedge clk) begin : mon_proc
    pixel_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.px = out_tdata[CB-1:0];
      got.py = out_tdata[2*CB-1:CB];
      got.last = out_tlast;
      got.idle = out_tuser[0];
      got.rejected = out_tuser[1];
      if (pending_pixels.size() == 0) begin
        $error("result transaction with no pixel expected");
        err_cnt++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", int'(want.px), int'(got.px));
        check_field("pixel_y", int'(want.py), int'(got.py));
        check_field("last", int'(want.last), int'(got.last));
        check_field("idle", int'(want.idle), int'(got.idle));
        check_field("rejected", int'(want.rejected), int'(got.rejected));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("dda_line_rasterizer_top_tb: errors");
      $finish;
    end
  end

endmodule
